FILE: hdl/sam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sam_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int ALPHABET   = 26;

  localparam int LETTER_W = 5;
  localparam int MODE_W   = 2;
  localparam int PTR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_PATTERN = 2'd1,
    MODE_TEXT    = 2'd2
  } mode_t;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // (ptr - len) mod MAX_WINDOW, with len <= MAX_WINDOW
  function automatic ptr_t ring_sub(input ptr_t ptr, input cnt_t len);
    logic [CNT_W:0] p;
    logic [CNT_W:0] l;
    logic [CNT_W:0] r;
    p = (CNT_W + 1)'(ptr);
    l = (CNT_W + 1)'(len);
    if (p >= l) begin
      r = p - l;
    end else begin
      r = p + (CNT_W + 1)'(MAX_WINDOW) - l;
    end
    return r[PTR_W-1:0];
  endfunction

  function automatic ptr_t ring_inc(input ptr_t ptr);
    ptr_t r;
    if (ptr == PTR_W'(MAX_WINDOW - 1)) begin
      r = '0;
    end else begin
      r = ptr + PTR_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sam_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sam_in_if
  import sam_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [LETTER_W-1:0] letter;

  modport source (output valid, output mode, output letter, input ready);
  modport sink   (input valid, input mode, input letter, output ready);
endinterface

interface sam_out_if;
  logic valid;
  logic ready;
  logic match_here;
  logic found;
  logic pattern_dropped;

  modport source (output valid, output match_here, output found, output pattern_dropped,
                  input ready);
  modport sink   (input valid, input match_here, input found, input pattern_dropped,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/sliding_anagram_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload                              Transaction
// in_if    in   mode[1:0], letter[4:0]               valid && ready
// out_if   out  match_here, found, pattern_dropped   valid && ready
//
// One transaction per cycle unless out_if stalls; each accepted input produces one result in the next cycle.
// Letter counts, window fill and the ring pointer update at the accepting edge.
// The leaving letter comes from a registered-read ring RAM, addressed ahead
// from the next-state pointer, with a bypass when the window is one letter long.
// in_if.ready stays high while the result register is empty or being drained.
// rst_n (synchronous) clears counts, pointer, found and valid flags; result payload and ring contents stay undefined.
module sliding_anagram_matcher
  import sam_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sam_in_if.sink    in_if,
  sam_out_if.source out_if
);

  logic    acc;
  logic    letter_ok;
  logic    text_go;

  cnt_t    pc_r  [ALPHABET];
  cnt_t    pc_nxt[ALPHABET];
  cnt_t    wc_r  [ALPHABET];
  cnt_t    wc_nxt[ALPHABET];
  ptr_t    ptr_r, ptr_nxt;
  cnt_t    plen_r, plen_nxt;
  cnt_t    seen_r, seen_nxt;
  logic    found_r, found_nxt;

  logic    out_valid_r, out_valid_nxt;
  logic    match_r, match_nxt;
  logic    found_out_r;
  logic    dropped_r, dropped_nxt;

  logic    byp_r;
  letter_t byp_data_r;
  letter_t ram_q;
  letter_t old_letter;
  ptr_t    rd_addr;
  logic    ram_we;

  assign acc          = in_if.valid && in_if.ready;
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign letter_ok    = int'(in_if.letter) < ALPHABET;
  assign text_go      = acc && (in_if.mode == MODE_TEXT) && letter_ok && (plen_r != '0);
  assign ram_we       = text_go;
  assign old_letter   = byp_r ? byp_data_r : ram_q;
  assign rd_addr      = ring_sub(ptr_nxt, plen_nxt);

  sam_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (in_if.letter),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    logic full;
    logic dec_ok;
    logic all_eq;
    full   = seen_r >= plen_r;
    dec_ok = 1'b0;
    all_eq = 1'b1;

    pc_nxt      = pc_r;
    wc_nxt      = wc_r;
    ptr_nxt     = ptr_r;
    plen_nxt    = plen_r;
    seen_nxt    = seen_r;
    found_nxt   = found_r;
    match_nxt   = 1'b0;
    dropped_nxt = 1'b0;

    if (acc) begin
      case (in_if.mode)
        MODE_CLEAR: begin
          for (int k = 0; k < ALPHABET; k++) begin
            pc_nxt[k] = '0;
            wc_nxt[k] = '0;
          end
          ptr_nxt   = '0;
          plen_nxt  = '0;
          seen_nxt  = '0;
          found_nxt = 1'b0;
        end
        MODE_PATTERN: begin
          if (letter_ok) begin
            if (int'(plen_r) >= MAX_WINDOW) begin
              dropped_nxt = 1'b1;
            end else begin
              for (int k = 0; k < ALPHABET; k++) begin
                if (in_if.letter == LETTER_W'(k)) begin
                  pc_nxt[k] = pc_r[k] + CNT_W'(1);
                end
                wc_nxt[k] = '0;
              end
              plen_nxt = plen_r + CNT_W'(1);
              seen_nxt = '0;
              ptr_nxt  = '0;
            end
          end
        end
        MODE_TEXT: begin
          if (letter_ok) begin
            if (plen_r == '0) begin
              match_nxt = 1'b1;
              found_nxt = 1'b1;
            end else begin
              if (!full) begin
                seen_nxt = seen_r + CNT_W'(1);
              end
              for (int k = 0; k < ALPHABET; k++) begin
                dec_ok = full && (old_letter == LETTER_W'(k)) && (wc_r[k] != '0);
                wc_nxt[k] = wc_r[k] - CNT_W'(dec_ok)
                            + CNT_W'(in_if.letter == LETTER_W'(k));
                if (wc_nxt[k] != pc_r[k]) begin
                  all_eq = 1'b0;
                end
              end
              ptr_nxt = ring_inc(ptr_r);
              if ((seen_nxt == plen_r) && all_eq) begin
                match_nxt = 1'b1;
                found_nxt = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ALPHABET; k++) begin
        pc_r[k] <= '0;
        wc_r[k] <= '0;
      end
      ptr_r       <= '0;
      plen_r      <= '0;
      seen_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      wc_r        <= wc_nxt;
      ptr_r       <= ptr_nxt;
      plen_r      <= plen_nxt;
      seen_r      <= seen_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      // RAM returns the pre-write word when read and write hit the same slot
      byp_r       <= ram_we && (rd_addr == ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= in_if.letter;
    if (acc) begin
      match_r     <= match_nxt;
      found_out_r <= found_nxt || (plen_nxt == '0);
      dropped_r   <= dropped_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.match_here      = match_r;
  assign out_if.found           = found_out_r;
  assign out_if.pattern_dropped = dropped_r;

  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= plen_r)
    else $error("window fill exceeds pattern length");

  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!match_r || found_out_r))
    else $error("match reported without found");

  a_match_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(match_r && dropped_r))
    else $error("match and drop in one result");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_if.mode == MODE_CLEAR)) |=>
      (out_valid_r && found_out_r && !match_r && !dropped_r && (plen_r == '0)))
    else $error("clear transaction gave wrong result");

endmodule
`default_nettype wire

FILE: hdl/sam_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
